@@ src/sli_pkg.sv @@
package sli_pkg;

    localparam int NUM_JOINTS_DEF = 16;
    localparam int MAX_OUT        = 16;

    localparam int TW  = 48;   // timestamp width
    localparam int PSW = 24;   // position width
    localparam int VW  = 32;   // velocity width
    localparam int DW  = 20;   // default duration width
    localparam int CIW = 2;    // config index width

    // multiply/divide unit widths: floor(a * b / c)
    localparam int MD_AW = PSW + 1;
    localparam int MD_PW = MD_AW + TW;

    localparam logic [TW-1:0]  T_MAX      = {TW{1'b1}};
    localparam logic [TW-1:0]  US_PER_S   = TW'(1000000);
    localparam logic [DW-1:0]  DFLT_RESET = DW'(16667);
    localparam logic [VW-1:0]  VEL_POS_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0]  VEL_NEG_MAX = {1'b1, {(VW-1){1'b0}}};

    localparam logic [CIW-1:0] REG_VFF_EN = 2'd0;
    localparam logic [CIW-1:0] REG_DFLT   = 2'd1;

    typedef struct packed {
        logic                  kind;
        logic [TW-1:0]         time_us;
        logic [3:0]            joint;
        logic signed [PSW-1:0] position;
        logic                  frame_end;
    } sli_item_t;

    typedef struct packed {
        logic [3:0]            out_joint;
        logic signed [PSW-1:0] out_position;
        logic signed [VW-1:0]  out_velocity;
        logic                  from_target;
        logic                  last;
    } sli_result_t;

    typedef struct packed {
        logic [CIW-1:0] index;
        logic [DW-1:0]  value;
    } sli_cfg_t;

    typedef struct packed {
        logic [MD_AW-1:0] a;
        logic [TW-1:0]    b;
        logic [TW-1:0]    c;
    } sli_md_req_t;

endpackage

@@ src/sli_item_if.sv @@
interface sli_item_if import sli_pkg::*; ();
    logic      valid;
    logic      ready;
    sli_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ src/sli_result_if.sv @@
interface sli_result_if import sli_pkg::*; ();
    logic        valid;
    logic        ready;
    sli_result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ src/sli_cfg_if.sv @@
interface sli_cfg_if import sli_pkg::*; ();
    logic     valid;
    logic     ready;
    sli_cfg_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ src/sli_muldiv.sv @@
module sli_muldiv import sli_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  sli_md_req_t       req,
    output logic              done,
    output logic [MD_PW-1:0]  quot
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_DIV  = 2'd2;
    localparam int CNTW = $clog2(MD_PW);

    logic [1:0]       phase_reg;
    logic [CNTW-1:0]  cnt_reg;
    logic             done_reg;
    logic [MD_AW-1:0] a_reg;
    logic [TW-1:0]    b_reg;
    logic [TW-1:0]    c_reg;
    logic [MD_PW-1:0] p_reg;
    logic [TW-1:0]    r_reg;
    logic [MD_PW-1:0] q_reg;

    logic [TW:0]      r_shift;
    logic             r_ge;

    // one product bit or one quotient bit per cycle
    assign r_shift = {r_reg, p_reg[MD_PW-1]};
    assign r_ge    = r_shift >= {1'b0, c_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else begin
            done_reg <= 1'b0;
            case (phase_reg)
                PH_IDLE:
                begin
                    if (start) begin
                        phase_reg <= PH_MUL;
                        cnt_reg   <= '0;
                    end
                end
                PH_MUL:
                begin
                    if (cnt_reg == CNTW'(MD_AW - 1)) begin
                        phase_reg <= PH_DIV;
                        cnt_reg   <= '0;
                    end
                    else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                PH_DIV:
                begin
                    if (cnt_reg == CNTW'(MD_PW - 1)) begin
                        phase_reg <= PH_IDLE;
                        done_reg  <= 1'b1;
                    end
                    else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                default:
                begin
                    phase_reg <= PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk) begin
        case (phase_reg)
            PH_IDLE:
            begin
                if (start) begin
                    a_reg <= req.a;
                    b_reg <= req.b;
                    c_reg <= req.c;
                    p_reg <= '0;
                    r_reg <= '0;
                    q_reg <= '0;
                end
            end
            PH_MUL:
            begin
                p_reg <= {p_reg[MD_PW-2:0], 1'b0}
                         + (a_reg[MD_AW-1] ? {{MD_AW{1'b0}}, b_reg} : {MD_PW{1'b0}});
                a_reg <= {a_reg[MD_AW-2:0], 1'b0};
            end
            PH_DIV:
            begin
                r_reg <= r_ge ? TW'(r_shift - {1'b0, c_reg}) : r_shift[TW-1:0];
                q_reg <= {q_reg[MD_PW-2:0], r_ge};
                p_reg <= {p_reg[MD_PW-2:0], 1'b0};
            end
            default:
            begin
                p_reg <= p_reg;
            end
        endcase
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

@@ src/setpoint_linear_interpolator_top.sv @@
// Channel  | Dir | Transaction
// ---------+-----+----------------------------------------------------------
// item     | in  | target joint value (kind 0) or sample tick (kind 1)
// result   | out | target echo, or one interpolated setpoint per joint
// cfg      | in  | register write: 0 velocity_ff_enable, 1 default_duration_us
//
// A target transaction runs setup S_IVL to S_RD, up to two passes of the shared
// bit-serial multiply/divide unit (25 product bits, 73 quotient bits) for
// interpolation and velocity, then write and emit, and a commit on frame_end. A
// tick without a committed segment is dropped; else it runs S_LEN to S_FIN, then
// reads, interpolates and emits each joint in turn. Reset clears control, config
// and segment timing only. A stalled result holds in the output register.
module setpoint_linear_interpolator_top import sli_pkg::*; #(
    parameter int NUM_JOINTS = NUM_JOINTS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    sli_item_if.sink     item,
    sli_result_if.source result,
    sli_cfg_if.sink      cfg
);

    localparam int JW   = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
    localparam int NOUT = (NUM_JOINTS > MAX_OUT) ? MAX_OUT : NUM_JOINTS;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_IVL    = 4'd1;
    localparam logic [3:0] S_LEN    = 4'd2;
    localparam logic [3:0] S_BEG    = 4'd3;
    localparam logic [3:0] S_FIN    = 4'd4;
    localparam logic [3:0] S_RD     = 4'd5;
    localparam logic [3:0] S_INT    = 4'd6;
    localparam logic [3:0] S_INTW   = 4'd7;
    localparam logic [3:0] S_VEL    = 4'd8;
    localparam logic [3:0] S_VELW   = 4'd9;
    localparam logic [3:0] S_WR     = 4'd10;
    localparam logic [3:0] S_EMIT   = 4'd11;
    localparam logic [3:0] S_COMMIT = 4'd12;

    // sequencer and item registers
    logic [3:0]            state_reg;
    logic                  kind_reg;
    logic [TW-1:0]         t_reg;
    logic [3:0]            joint_reg;
    logic signed [PSW-1:0] pos_reg;
    logic                  fe_reg;
    logic [JW-1:0]         idx_reg;
    logic                  jok_reg;
    logic                  ivl_ok_reg;
    logic [TW-1:0]         dur_reg;
    logic                  len_bad_reg;
    logic [TW-1:0]         len_reg;
    logic                  t_le_beg_reg;
    logic [TW-1:0]         el_reg;
    logic                  t_ge_fin_reg;
    logic                  neg_reg;
    logic signed [PSW-1:0] cur_reg;
    logic signed [VW-1:0]  rate_reg;

    // segment timing and configuration
    logic [TW-1:0]         seg_begin_reg;
    logic [TW-1:0]         seg_finish_reg;
    logic [TW-1:0]         prev_time_reg;
    logic                  seg_valid_reg;
    logic                  frame_seen_reg;
    logic                  vff_reg;
    logic [DW-1:0]         dflt_reg;

    // output register
    logic                  out_valid_reg;
    sli_result_t           out_reg;

    // per-joint stores
    logic signed [PSW-1:0] start_mem [NUM_JOINTS];
    logic signed [PSW-1:0] goal_mem  [NUM_JOINTS];
    logic signed [VW-1:0]  rate_mem  [NUM_JOINTS];
    logic signed [PSW-1:0] rd_start_reg;
    logic signed [PSW-1:0] rd_goal_reg;
    logic signed [VW-1:0]  rd_rate_reg;

    logic                  item_acc;
    logic                  out_free;
    logic                  out_load;
    logic                  mem_we;
    logic                  md_start;
    sli_md_req_t           md_req;
    logic                  md_done;
    logic [MD_PW-1:0]      md_quot;

    logic [TW:0]           ivl_diff;
    logic [TW:0]           len_diff;
    logic [TW:0]           el_diff;
    logic [TW:0]           fin_sum;
    logic [TW-1:0]         commit_len;
    logic signed [PSW:0]   int_diff;
    logic signed [PSW:0]   vel_diff;
    logic [MD_AW-1:0]      int_abs;
    logic [MD_AW-1:0]      vel_abs;
    logic signed [PSW-1:0] int_res;
    logic signed [VW-1:0]  vel_sat;
    logic                  tick_last;

    assign item_acc = item.valid && item.ready;
    assign item.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign out_free = !out_valid_reg || result.ready;
    assign out_load = (state_reg == S_EMIT) && out_free;
    assign mem_we = (state_reg == S_WR);
    assign result.valid = out_valid_reg;
    assign result.data = out_reg;

    // setup arithmetic: one wide subtract each for S_IVL, S_LEN and S_BEG, one add for commit
    assign ivl_diff = {1'b0, t_reg} - {1'b0, prev_time_reg};
    assign len_diff = {1'b0, seg_finish_reg} - {1'b0, seg_begin_reg};
    assign el_diff  = {1'b0, t_reg} - {1'b0, seg_begin_reg};
    assign commit_len = (dur_reg == '0) ? TW'(1) : dur_reg;
    assign fin_sum  = {1'b0, t_reg} + {1'b0, commit_len};

    assign int_diff = {rd_goal_reg[PSW-1], rd_goal_reg} - {rd_start_reg[PSW-1], rd_start_reg};
    assign vel_diff = {pos_reg[PSW-1], pos_reg} - {rd_goal_reg[PSW-1], rd_goal_reg};
    assign int_abs  = int_diff[PSW] ? MD_AW'(-int_diff) : MD_AW'(int_diff);
    assign vel_abs  = vel_diff[PSW] ? MD_AW'(-vel_diff) : MD_AW'(vel_diff);

    // quotient magnitude is below |goal - start|, so 24 bits carry it
    assign int_res = neg_reg ? rd_start_reg - $signed(md_quot[PSW-1:0])
                             : rd_start_reg + $signed(md_quot[PSW-1:0]);

    always_comb begin
        if (!neg_reg) begin
            vel_sat = (md_quot[MD_PW-1:VW-1] != '0) ? VEL_POS_MAX
                                                    : $signed({1'b0, md_quot[VW-2:0]});
        end
        else if ((md_quot[MD_PW-1:VW] != '0) ||
                 (md_quot[VW-1] && (md_quot[VW-2:0] != '0))) begin
            vel_sat = VEL_NEG_MAX;
        end
        else begin
            vel_sat = -$signed(md_quot[VW-1:0]);
        end
    end

    always_comb begin
        md_start = 1'b0;
        md_req.a = int_abs;
        md_req.b = el_reg;
        md_req.c = len_reg;
        if (state_reg == S_INT) begin
            md_start = seg_valid_reg && !len_bad_reg && !t_ge_fin_reg && !t_le_beg_reg;
        end
        else if (state_reg == S_VEL) begin
            md_start = ivl_ok_reg && seg_valid_reg;
            md_req.a = vel_abs;
            md_req.b = US_PER_S;
            md_req.c = dur_reg;
        end
    end

    assign tick_last = (idx_reg == JW'(NOUT - 1));

    sli_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (md_start),
        .req   (md_req),
        .done  (md_done),
        .quot  (md_quot)
    );

    // joint stores: one write and one registered read per cycle
    always_ff @(posedge clk) begin
        if (mem_we) begin
            start_mem[idx_reg] <= cur_reg;
            goal_mem[idx_reg]  <= pos_reg;
            rate_mem[idx_reg]  <= rate_reg;
        end
        rd_start_reg <= start_mem[idx_reg];
        rd_goal_reg  <= goal_mem[idx_reg];
        rd_rate_reg  <= rate_mem[idx_reg];
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vff_reg  <= 1'b1;
            dflt_reg <= DFLT_RESET;
        end
        else if (cfg.valid && cfg.ready) begin
            case (cfg.data.index)
                REG_VFF_EN: vff_reg  <= cfg.data.value[0];
                REG_DFLT:   dflt_reg <= cfg.data.value;
                default:    vff_reg  <= vff_reg;
            endcase
        end
    end

    // sequencer and segment state
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg      <= S_IDLE;
            seg_begin_reg  <= '0;
            seg_finish_reg <= '0;
            prev_time_reg  <= '0;
            seg_valid_reg  <= 1'b0;
            frame_seen_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else begin
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (item_acc) begin
                        if (!item.data.kind) begin
                            state_reg <= S_IVL;
                        end
                        else if (seg_valid_reg) begin
                            state_reg <= S_LEN;
                        end
                    end
                end
                S_IVL:    state_reg <= S_LEN;
                S_LEN:    state_reg <= S_BEG;
                S_BEG:    state_reg <= S_FIN;
                S_FIN:    state_reg <= (!kind_reg && !jok_reg) ? S_EMIT : S_RD;
                S_RD:     state_reg <= S_INT;
                S_INT:
                begin
                    if (md_start) begin
                        state_reg <= S_INTW;
                    end
                    else begin
                        state_reg <= kind_reg ? S_EMIT : S_VEL;
                    end
                end
                S_INTW:
                begin
                    if (md_done) begin
                        state_reg <= kind_reg ? S_EMIT : S_VEL;
                    end
                end
                S_VEL:    state_reg <= md_start ? S_VELW : S_WR;
                S_VELW:
                begin
                    if (md_done) begin
                        state_reg <= S_WR;
                    end
                end
                S_WR:     state_reg <= S_EMIT;
                S_EMIT:
                begin
                    if (out_free) begin
                        if (!kind_reg) begin
                            state_reg <= fe_reg ? S_COMMIT : S_IDLE;
                        end
                        else begin
                            state_reg <= tick_last ? S_IDLE : S_RD;
                        end
                    end
                end
                S_COMMIT:
                begin
                    seg_begin_reg  <= t_reg;
                    seg_finish_reg <= fin_sum[TW] ? T_MAX : fin_sum[TW-1:0];
                    prev_time_reg  <= t_reg;
                    frame_seen_reg <= 1'b1;
                    seg_valid_reg  <= 1'b1;
                    state_reg      <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk) begin
        case (state_reg)
            S_IDLE:
            begin
                if (item_acc) begin
                    kind_reg  <= item.data.kind;
                    t_reg     <= item.data.time_us;
                    joint_reg <= item.data.joint;
                    pos_reg   <= item.data.position;
                    fe_reg    <= item.data.frame_end;
                    jok_reg   <= 7'(item.data.joint) < 7'(NUM_JOINTS);
                    idx_reg   <= item.data.kind ? '0 : JW'(item.data.joint);
                end
            end
            S_IVL:
            begin
                // take the frame interval only when it runs forward by more than 1 us
                ivl_ok_reg <= frame_seen_reg && !ivl_diff[TW] && (ivl_diff[TW-1:0] > TW'(1));
                dur_reg    <= (frame_seen_reg && !ivl_diff[TW] && (ivl_diff[TW-1:0] > TW'(1)))
                              ? ivl_diff[TW-1:0] : TW'(dflt_reg);
            end
            S_LEN:
            begin
                len_reg     <= len_diff[TW-1:0];
                len_bad_reg <= len_diff[TW] || (len_diff[TW-1:0] <= TW'(1));
            end
            S_BEG:
            begin
                el_reg       <= el_diff[TW-1:0];
                t_le_beg_reg <= el_diff[TW] || (el_diff[TW-1:0] == '0);
            end
            S_FIN:
            begin
                t_ge_fin_reg <= t_reg >= seg_finish_reg;
                rate_reg     <= '0;
            end
            S_INT:
            begin
                neg_reg <= int_diff[PSW];
                if (!seg_valid_reg) begin
                    cur_reg <= pos_reg;
                end
                else if (len_bad_reg || t_ge_fin_reg) begin
                    cur_reg <= rd_goal_reg;
                end
                else begin
                    cur_reg <= rd_start_reg;
                end
            end
            S_INTW:
            begin
                if (md_done) begin
                    cur_reg <= int_res;
                end
            end
            S_VEL:
            begin
                neg_reg  <= vel_diff[PSW];
                rate_reg <= '0;
            end
            S_VELW:
            begin
                if (md_done) begin
                    rate_reg <= vel_sat;
                end
            end
            S_EMIT:
            begin
                if (out_free) begin
                    if (!kind_reg) begin
                        out_reg.out_joint    <= joint_reg;
                        out_reg.out_position <= pos_reg;
                        out_reg.out_velocity <= vff_reg ? rate_reg : '0;
                        out_reg.from_target  <= 1'b1;
                        out_reg.last         <= 1'b1;
                    end
                    else begin
                        out_reg.out_joint    <= 4'(idx_reg);
                        out_reg.out_position <= cur_reg;
                        out_reg.out_velocity <= vff_reg ? rd_rate_reg : '0;
                        out_reg.from_target  <= 1'b0;
                        out_reg.last         <= tick_last;
                        // advance to the next joint
                        if (!tick_last) begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                cur_reg <= cur_reg;
            end
        endcase
    end

    // a target echo is always the only result of its transaction
    a_target_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.from_target |-> out_reg.last)
        else $error("target echo without last");

    // never overwrite a result that has not been taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || result.ready))
        else $error("result overwritten");

    // once a segment exists it stays
    a_seg_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid_reg |=> seg_valid_reg)
        else $error("segment valid dropped");

    // the divider only finishes while the sequencer waits for it
    a_md_wait: assert property (@(posedge clk) disable iff (!rst_n)
        md_done |-> (state_reg == S_INTW || state_reg == S_VELW))
        else $error("divider result unclaimed");

endmodule
